[src/rhf_pkg.sv]
`default_nettype none

package rhf_pkg;

   localparam int unsigned HDR_BYTES = 20;

   // Byte offsets within the IPv4 header
   localparam int unsigned OFS_VERSION  = 0;
   localparam int unsigned OFS_PROTOCOL = 9;
   localparam int unsigned OFS_CHECKSUM = 11;
   localparam int unsigned OFS_DEST     = 16;

   localparam logic [7:0]  VERSION_IHL_OK = 8'h45;
   localparam logic [7:0]  PROTO_ICMP     = 8'h01;
   localparam logic [15:0] SUM_ALL_ONES   = 16'hFFFF;

   typedef enum logic [2:0] {
      VERDICT_SHORT    = 3'd0,
      VERDICT_BAD_VER  = 3'd1,
      VERDICT_BAD_CSUM = 3'd2,
      VERDICT_NOT_LOCAL = 3'd3,
      VERDICT_OTHER    = 3'd4,
      VERDICT_ICMP     = 3'd5
   } verdict_type;

   // Header fields as they stand after the current byte
   typedef struct packed {
      logic        min_reached;
      logic [7:0]  version_length;
      logic [15:0] running_sum;
      logic [15:0] stored_checksum;
      logic [31:0] destination;
      logic [7:0]  protocol;
   } hdr_snap_type;

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

`default_nettype wire

[src/rhf_csr.sv]
`default_nettype none

module rhf_csr import rhf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [31:0]      local_address
);

   logic [31:0] local_address_ff;
   logic [31:0] local_address_in;
   logic        sel_local;

   assign sel_local  = (csr_paddr[2] == 1'b0);
   assign csr_pready = 1'b1;

   always_comb begin
      local_address_in = local_address_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_local) begin
         local_address_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
      end else begin
         local_address_ff <= local_address_in;
      end
   end

   assign csr_prdata    = sel_local ? local_address_ff : 32'd0;
   assign local_address = local_address_ff;

endmodule

`default_nettype wire

[src/rhf_hdr_parse.sv]
`default_nettype none

module rhf_hdr_parse import rhf_pkg::*; #(
   parameter int unsigned LINK_HEADER_BYTES = 14
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output hdr_snap_type    snap
);

   localparam int unsigned POS_W = $clog2(LINK_HEADER_BYTES + HDR_BYTES + 1);
   localparam logic [POS_W-1:0] LINK_POS  = POS_W'(LINK_HEADER_BYTES);
   localparam logic [POS_W-1:0] FRAME_MIN = POS_W'(LINK_HEADER_BYTES + HDR_BYTES);

   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [15:0]      sum_ff,  sum_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       vl_ff,   vl_in;
   logic [15:0]      chk_ff,  chk_in;
   logic [31:0]      dest_ff, dest_in;
   logic [7:0]       proto_ff, proto_in;
   logic [POS_W-1:0] hdr_offset;
   logic [15:0]      word;

   assign hdr_offset = pos_ff - LINK_POS;
   assign word       = {high_ff, data_byte};

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      high_in  = high_ff;
      vl_in    = vl_ff;
      chk_in   = chk_ff;
      dest_in  = dest_ff;
      proto_in = proto_ff;
      if (pos_ff < FRAME_MIN) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff >= LINK_POS) begin
            if (hdr_offset == POS_W'(OFS_VERSION)) begin
               vl_in = data_byte;
            end
            if (hdr_offset == POS_W'(OFS_PROTOCOL)) begin
               proto_in = data_byte;
            end
            if (hdr_offset >= POS_W'(OFS_DEST)) begin
               dest_in = {dest_ff[23:0], data_byte};
            end
            if (!hdr_offset[0]) begin
               high_in = data_byte;
            end else if (hdr_offset == POS_W'(OFS_CHECKSUM)) begin
               // checksum word counts as zero in the sum
               chk_in = word;
               sum_in = fold_add(sum_ff, 16'd0);
            end else begin
               sum_in = fold_add(sum_ff, word);
            end
         end
      end
   end

   always_comb begin
      snap.min_reached     = (pos_in == FRAME_MIN);
      snap.version_length  = vl_in;
      snap.running_sum     = sum_in;
      snap.stored_checksum = chk_in;
      snap.destination     = dest_in;
      snap.protocol        = proto_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         high_ff  <= '0;
         vl_ff    <= '0;
         chk_ff   <= '0;
         dest_ff  <= '0;
         proto_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
         vl_ff    <= vl_in;
         chk_ff   <= chk_in;
         dest_ff  <= dest_in;
         proto_ff <= proto_in;
      end
   end

endmodule

`default_nettype wire

[src/rhf_verdict.sv]
`default_nettype none

module rhf_verdict import rhf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  hdr_snap_type     snap,
   input  wire logic [31:0] local_address,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [2:0]       rsp_verdict,
   output logic [7:0]       rsp_protocol,
   output logic             out_free
);

   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff,   verdict_in;
   logic [7:0]  protocol_ff;
   logic [15:0] check_sum;

   assign check_sum = fold_add(snap.stored_checksum, ~snap.running_sum);

   always_comb begin
      if (!snap.min_reached) begin
         verdict_in = VERDICT_SHORT;
      end else if (snap.version_length != VERSION_IHL_OK) begin
         verdict_in = VERDICT_BAD_VER;
      end else if (check_sum != SUM_ALL_ONES) begin
         verdict_in = VERDICT_BAD_CSUM;
      end else if (snap.destination != local_address) begin
         verdict_in = VERDICT_NOT_LOCAL;
      end else if (snap.protocol != PROTO_ICMP) begin
         verdict_in = VERDICT_OTHER;
      end else begin
         verdict_in = VERDICT_ICMP;
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff  <= verdict_in;
         protocol_ff <= snap.protocol;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_verdict  = verdict_ff;
   assign rsp_protocol = protocol_ff;

endmodule

`default_nettype wire

[src/ipv4_receive_header_filter.sv]
// Result path: a final byte is held in the input register, and its verdict is then
// registered in the result register, from which rsp_valid presents it.
// Throughput: one frame byte per clock; only a final byte waits in the input register,
// and only while the result register still holds an untaken verdict.
// Reset (synchronous, active high) clears local_address, all frame state and both
// valid flags; no result is pending after reset.
`default_nettype none

module ipv4_receive_header_filter import rhf_pkg::*; #(
   parameter int unsigned LINK_HEADER_BYTES = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_verdict,
   output logic [7:0]       rsp_protocol,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         advance;
   logic         out_free;
   logic         req_accept;
   logic [31:0]  local_address;
   hdr_snap_type snap;

   // hold a final byte until the result slot can take its verdict
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready   = !in_valid_ff || advance;
   assign req_accept  = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   rhf_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .local_address (local_address)
   );

   rhf_hdr_parse #(
      .LINK_HEADER_BYTES (LINK_HEADER_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .snap      (snap)
   );

   rhf_verdict u_verdict (
      .clock         (clock),
      .reset         (reset),
      .load          (advance && in_last_ff),
      .snap          (snap),
      .local_address (local_address),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_verdict   (rsp_verdict),
      .rsp_protocol  (rsp_protocol),
      .out_free      (out_free)
   );

endmodule

`default_nettype wire

[dv/tb_ipv4_receive_header_filter.sv]
`timescale 1ns / 100ps

module tb_ipv4_receive_header_filter;
   import rhf_pkg::*;

   localparam int unsigned LINK_BYTES = 14;
   localparam int unsigned FRAME_MIN  = LINK_BYTES + HDR_BYTES;
   localparam logic [2:0]  CSR_LOCAL_ADDRESS = 3'd0;
   localparam int unsigned IDLE_PERCENT = 28;

   typedef struct {
      verdict_type verdict;
      logic [7:0]  protocol;
   } verdict_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_verdict;
   logic [7:0]  rsp_protocol;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // frame predictor state
   logic [5:0]  frame_pos;
   logic [15:0] hdr_sum;
   logic [7:0]  word_high;
   logic [7:0]  ver_ihl_seen;
   logic [15:0] csum_seen;
   logic [31:0] dest_seen;
   logic [7:0]  proto_seen;
   logic [31:0] host_address;

   verdict_rec_type verdicts_due[$];
   logic [7:0]  frame_bytes[$];
   bit          steady = 1'b0;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          verdicts_seen = 0;
   int          address_settings = 0;
   int          verdict_count[6];

   ipv4_receive_header_filter i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_verdict   (rsp_verdict),
      .rsp_protocol  (rsp_protocol),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #4 clock = ~clock;

   initial begin
      #4_000_000;
      $display("FAIL ipv4_receive_header_filter");
      $finish;
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   function automatic void clear_frame_state();
      frame_pos    = '0;
      hdr_sum      = '0;
      word_high    = '0;
      ver_ihl_seen = '0;
      csum_seen    = '0;
      dest_seen    = '0;
      proto_seen   = '0;
   endfunction

   // advance the header tracker by one byte; returns 1 when a verdict falls due
   function automatic bit filter_byte(input logic [7:0] b, input logic last,
                                      output verdict_rec_type rec);
      int unsigned ofs;
      logic [15:0] word;
      rec.verdict  = VERDICT_SHORT;
      rec.protocol = '0;
      if (frame_pos < FRAME_MIN) begin
         if (frame_pos >= LINK_BYTES) begin
            ofs = frame_pos - LINK_BYTES;
            if (ofs == OFS_VERSION) ver_ihl_seen = b;
            if (ofs == OFS_PROTOCOL) proto_seen = b;
            if (ofs >= OFS_DEST) dest_seen = {dest_seen[23:0], b};
            if (ofs[0] == 1'b0) begin
               word_high = b;
            end else begin
               word = {word_high, b};
               if (ofs == OFS_CHECKSUM) begin
                  csum_seen = word;
                  word = '0;
               end
               hdr_sum = ones_add(hdr_sum, word);
            end
         end
         frame_pos = frame_pos + 6'd1;
      end
      if (!last) return 1'b0;
      if (frame_pos < FRAME_MIN)
         rec.verdict = VERDICT_SHORT;
      else if (ver_ihl_seen != VERSION_IHL_OK)
         rec.verdict = VERDICT_BAD_VER;
      else if (ones_add(csum_seen, ~hdr_sum) != SUM_ALL_ONES)
         rec.verdict = VERDICT_BAD_CSUM;
      else if (dest_seen != host_address)
         rec.verdict = VERDICT_NOT_LOCAL;
      else if (proto_seen != PROTO_ICMP)
         rec.verdict = VERDICT_OTHER;
      else
         rec.verdict = VERDICT_ICMP;
      rec.protocol = proto_seen;
      clear_frame_state();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // result checker
   always @(posedge clock) begin
      verdict_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts_seen++;
         if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("unexpected verdict %0d protocol 0x%02h",
                                      rsp_verdict, rsp_protocol));
         end else begin
            want = verdicts_due.pop_front();
            verdict_count[want.verdict]++;
            if (rsp_verdict !== want.verdict)
               report_mismatch($sformatf("verdict expected %0d actual %0d",
                                         want.verdict, rsp_verdict));
            if (rsp_protocol !== want.protocol)
               report_mismatch($sformatf("protocol expected 0x%02h actual 0x%02h",
                                         want.protocol, rsp_protocol));
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Present one byte at a falling edge and hold it until accepted. Valid is left
   // high on return; anything that lets time pass afterwards lowers it first.
   task automatic send_byte(input logic [7:0] b, input logic last);
      verdict_rec_type rec;
      while (take_break()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = b;
      req_last_byte = last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (filter_byte(b, last, rec)) verdicts_due.push_back(rec);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_local_address(input logic [31:0] value);
      wait_drained();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_LOCAL_ADDRESS;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      host_address = value;
      address_settings++;
      @(negedge clock);
      // read back
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value)
         report_mismatch($sformatf("local_address read expected 0x%08h actual 0x%08h",
                                   value, csr_prdata));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Build link header plus IPv4 header into frame_bytes; the stored checksum word is the ones'
   // complement sum of the other nine words, with one random bit flipped when csum_good is clear.
   task automatic build_frame(input logic [7:0] ver, input logic [7:0] proto,
                              input logic [31:0] dest, input bit csum_good);
      logic [7:0]  hdr[20];
      logic [15:0] acc;
      int          i;
      for (i = 0; i < 20; i++) hdr[i] = 8'($urandom_range(0, 255));
      hdr[OFS_VERSION]  = ver;
      hdr[OFS_PROTOCOL] = proto;
      for (i = 0; i < 4; i++) hdr[OFS_DEST + i] = dest[31 - 8*i -: 8];
      acc = '0;
      for (i = 0; i < 20; i += 2)
         if (i != OFS_CHECKSUM - 1) acc = ones_add(acc, {hdr[i], hdr[i + 1]});
      if (!csum_good) acc = acc ^ (16'h1 << $urandom_range(0, 15));
      hdr[OFS_CHECKSUM - 1] = acc[15:8];
      hdr[OFS_CHECKSUM]     = acc[7:0];
      frame_bytes.delete();
      for (i = 0; i < LINK_BYTES; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < 20; i++) frame_bytes.push_back(hdr[i]);
   endtask

   // send the first len bytes of the built frame, padding with random payload
   task automatic send_frame(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_byte(i < frame_bytes.size() ? frame_bytes[i] : 8'($urandom_range(0, 255)),
                   i == len - 1);
   endtask

   task automatic test_short_frames();
      set_local_address(32'hC0A8_0001);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, host_address, 1'b1);
      send_frame(1);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, host_address, 1'b1);
      send_frame(LINK_BYTES + OFS_PROTOCOL + 1);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, host_address, 1'b1);
      send_frame(FRAME_MIN - 1);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, host_address, 1'b1);
      send_frame(FRAME_MIN);
   endtask

   task automatic test_each_verdict();
      build_frame(8'h00, PROTO_ICMP, host_address, 1'b1);
      send_frame(FRAME_MIN);
      build_frame(8'hFF, 8'hFF, host_address, 1'b1);
      send_frame(FRAME_MIN + 2);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, host_address, 1'b0);
      send_frame(FRAME_MIN);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, host_address ^ 32'h8000_0000, 1'b1);
      send_frame(FRAME_MIN);
      build_frame(VERSION_IHL_OK, 8'h00, host_address, 1'b1);
      send_frame(FRAME_MIN);
      build_frame(VERSION_IHL_OK, 8'hFF, host_address, 1'b1);
      send_frame(FRAME_MIN);
      // payload well past the header saturates the byte count
      build_frame(VERSION_IHL_OK, PROTO_ICMP, host_address, 1'b1);
      send_frame(90);
   endtask

   task automatic test_address_extremes();
      set_local_address(32'h0000_0000);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, 32'h0000_0000, 1'b1);
      send_frame(FRAME_MIN);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, 32'h0000_0001, 1'b1);
      send_frame(FRAME_MIN);
      set_local_address(32'hFFFF_FFFF);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, 32'hFFFF_FFFF, 1'b1);
      send_frame(FRAME_MIN);
      build_frame(VERSION_IHL_OK, PROTO_ICMP, 32'hFFFF_FFFE, 1'b1);
      send_frame(FRAME_MIN);
   endtask

   task automatic send_random_frame();
      logic [7:0]  ver;
      logic [7:0]  proto;
      logic [31:0] dest;
      bit          good;
      int          pick;
      int          len;
      int          i;
      ver   = VERSION_IHL_OK;
      proto = PROTO_ICMP;
      dest  = host_address;
      good  = 1'b1;
      pick  = $urandom_range(0, 99);
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(FRAME_MIN, 90)
                                          : $urandom_range(FRAME_MIN, FRAME_MIN + 8);
      if (pick < 55) begin
      end else if (pick < 63) begin
         ver = 8'($urandom_range(0, 255));
      end else if (pick < 71) begin
         good = 1'b0;
      end else if (pick < 79) begin
         dest = $urandom_range(0, 1) ? $urandom() : host_address ^ (32'h1 << $urandom_range(0, 31));
      end else if (pick < 87) begin
         proto = 8'($urandom_range(0, 255));
      end else if (pick < 95) begin
         len = $urandom_range(1, FRAME_MIN - 1);
      end else begin
         // noise: random bytes with scattered end markers
         len = $urandom_range(1, 60);
         for (i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)),
                      (i == len - 1) || ($urandom_range(0, 29) == 0));
         return;
      end
      build_frame(ver, proto, dest, good);
      send_frame(len);
   endtask

   task automatic test_random_traffic(input int byte_goal, input int verdict_goal);
      int frames;
      int start_bytes;
      int start_due;
      frames      = 0;
      start_bytes = bytes_sent;
      start_due   = verdicts_seen + verdicts_due.size();
      while (bytes_sent - start_bytes < byte_goal ||
             verdicts_seen + verdicts_due.size() - start_due < verdict_goal) begin
         send_random_frame();
         frames++;
         if (frames % 20 == 0) begin
            // new host address between phases
            set_local_address($urandom());
         end else if (frames % 7 == 0) begin
            wait_drained();
         end
      end
   endtask

   task automatic test_back_to_back();
      int i;
      steady = 1'b1;
      for (i = 0; i < 5; i++) begin
         build_frame(VERSION_IHL_OK, ($urandom_range(0, 3) == 0) ? 8'h11 : PROTO_ICMP,
                     host_address, 1'b1);
         send_frame($urandom_range(FRAME_MIN, FRAME_MIN + 6));
      end
      wait_drained();
      steady = 1'b0;
   endtask

   initial begin
      host_address = '0;
      clear_frame_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_frames();
      test_each_verdict();
      test_address_extremes();
      set_local_address($urandom());
      test_random_traffic(180, 4);
      test_back_to_back();
      test_random_traffic(180, 4);

      wait_drained();
      if (verdicts_due.size() != 0)
         report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
      $display("Sent %0d frame bytes under %0d local addresses; checked %0d verdicts.",
               bytes_sent, address_settings, verdicts_seen);
      $display("Verdicts: short %0d, version %0d, checksum %0d, not local %0d, other %0d, icmp %0d",
               verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
               verdict_count[4], verdict_count[5]);
      if (mismatches == 0) begin
         $display("PASS ipv4_receive_header_filter");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL ipv4_receive_header_filter");
      end
      $finish;
   end

endmodule

[ipv4_receive_header_filter.f]
src/rhf_pkg.sv
src/rhf_csr.sv
src/rhf_hdr_parse.sv
src/rhf_verdict.sv
src/ipv4_receive_header_filter.sv
dv/tb_ipv4_receive_header_filter.sv
